// ----- sv/imafe_pkg.sv -----
// Shared types, constants and tables for the IMA ADPCM frame encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package imafe_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0]  IDX_MAX  = 7'd88;
    localparam logic [17:0] PRED_MAX = 18'sd32767;
    localparam logic [17:0] PRED_MIN = -18'sd32768;

    // Byte positions within one queued job
    localparam logic [2:0] POS_PRED_LO = 3'd0;
    localparam logic [2:0] POS_PRED_HI = 3'd1;
    localparam logic [2:0] POS_INDEX   = 3'd2;
    localparam logic [2:0] POS_ZERO    = 3'd3;
    localparam logic [2:0] POS_CODE    = 3'd4;

    // One job: optional frame header plus optional packed code byte
    typedef struct packed {
        logic        hdr;
        logic [15:0] pred;
        logic [6:0]  idx;
        logic        has_code;
        logic [7:0]  code_byte;
        logic        byte_last;
    } job_t;

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        unique case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Index adjustment by code magnitude; sign bit does not matter
    function automatic logic signed [4:0] index_move(input logic [3:0] code);
        logic signed [4:0] m;
        unique case (code[2:0])
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/imafe_front.sv -----
// Front end: accepts items, quantizes the sample, updates predictor and
// framing state, and hands a job to the queue. Depends on imafe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imafe_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic signed [15:0] sample,
    input  wire logic               frame_last,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output imafe_pkg::job_t         push_job
);

    logic signed [15:0] pred_reg, pred_next;
    logic [6:0]         pos_reg, pos_next;
    logic [3:0]         held_reg, held_next;
    logic               waiting_reg, waiting_next;
    logic               hdr_sent_reg, hdr_sent_next;

    logic               accept;
    logic [6:0]         idx;
    logic [14:0]        step;
    logic signed [16:0] diff;
    logic [15:0]        mag0, mag1, mag2;
    logic [3:0]         code;
    logic [15:0]        delta;
    logic signed [17:0] sum;
    logic signed [15:0] pred_upd;
    logic signed [8:0]  ni;
    logic [6:0]         idx_upd;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        idx  = (pos_reg > imafe_pkg::IDX_MAX) ? imafe_pkg::IDX_MAX : pos_reg;
        step = imafe_pkg::step_size(idx);
        diff = 17'(sample) - 17'(pred_reg);
        code[3] = diff[16];
        mag0 = diff[16] ? 16'(-diff) : diff[15:0];
        // Three compare-subtract steps against step, step/2, step/4
        code[2] = (mag0 >= {1'b0, step});
        mag1 = code[2] ? (mag0 - {1'b0, step}) : mag0;
        code[1] = (mag1 >= {2'b0, step[14:1]});
        mag2 = code[1] ? (mag1 - {2'b0, step[14:1]}) : mag1;
        code[0] = (mag2 >= {3'b0, step[14:2]});

        delta = {4'b0, step[14:3]}
              + (code[2] ? {1'b0, step} : 16'd0)
              + (code[1] ? {2'b0, step[14:1]} : 16'd0)
              + (code[0] ? {3'b0, step[14:2]} : 16'd0);
        sum = 18'(pred_reg) + (code[3] ? -$signed({2'b0, delta}) : $signed({2'b0, delta}));
        if (sum > $signed(imafe_pkg::PRED_MAX))
            pred_upd = 16'sh7FFF;
        else if (sum < $signed(imafe_pkg::PRED_MIN))
            pred_upd = -16'sh8000;
        else
            pred_upd = sum[15:0];

        ni = $signed({2'b0, idx}) + 9'(imafe_pkg::index_move(code));
        if (ni < 9'sd0)
            idx_upd = 7'd0;
        else if (ni > $signed({2'b0, imafe_pkg::IDX_MAX}))
            idx_upd = imafe_pkg::IDX_MAX;
        else
            idx_upd = ni[6:0];
    end

    always_comb
    begin
        push_job.hdr       = !hdr_sent_reg;
        push_job.pred      = pred_reg;
        push_job.idx       = idx;
        push_job.has_code  = waiting_reg || frame_last;
        push_job.code_byte = waiting_reg ? {code, held_reg} : {4'b0, code};
        push_job.byte_last = frame_last;
        push_valid = in_valid && !action && (!hdr_sent_reg || waiting_reg || frame_last);

        pred_next     = pred_reg;
        pos_next      = pos_reg;
        held_next     = held_reg;
        waiting_next  = waiting_reg;
        hdr_sent_next = hdr_sent_reg;
        if (accept)
        begin
            if (action)
            begin
                pred_next = '0;
                pos_next  = '0;
            end
            else
            begin
                pred_next     = pred_upd;
                pos_next      = idx_upd;
                hdr_sent_next = !frame_last;
                if (waiting_reg || frame_last)
                begin
                    waiting_next = 1'b0;
                    held_next    = '0;
                end
                else
                begin
                    waiting_next = 1'b1;
                    held_next    = code;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg     <= '0;
            pos_reg      <= '0;
            held_reg     <= '0;
            waiting_reg  <= 1'b0;
            hdr_sent_reg <= 1'b0;
        end
        else
        begin
            pred_reg     <= pred_next;
            pos_reg      <= pos_next;
            held_reg     <= held_next;
            waiting_reg  <= waiting_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/imafe_queue.sv -----
// Small job queue between front and back ends.
// Depends on imafe_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module imafe_queue
#(
    parameter int unsigned DEPTH = imafe_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire imafe_pkg::job_t push_job,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output imafe_pkg::job_t      pop_job
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    imafe_pkg::job_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/imafe_back.sv -----
// Back end: takes jobs from the queue and emits their bytes one per cycle
// while out_ready is high. Depends on imafe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imafe_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire imafe_pkg::job_t pop_job,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_byte,
    output logic                 frame_end
);

    imafe_pkg::job_t job_reg, job_next;
    logic            busy_reg, busy_next;
    logic [2:0]      pos_reg, pos_next;
    logic            advance, job_done;

    assign out_valid = busy_reg;
    assign advance   = busy_reg && out_ready;
    assign job_done  = (pos_reg == (job_reg.has_code ? imafe_pkg::POS_CODE
                                                    : imafe_pkg::POS_ZERO));
    assign pop_ready = !busy_reg || (advance && job_done);

    always_comb
    begin
        unique case (pos_reg)
            imafe_pkg::POS_PRED_LO: out_byte = job_reg.pred[7:0];
            imafe_pkg::POS_PRED_HI: out_byte = job_reg.pred[15:8];
            imafe_pkg::POS_INDEX:   out_byte = {1'b0, job_reg.idx};
            imafe_pkg::POS_CODE:    out_byte = job_reg.code_byte;
            default:                out_byte = 8'h00;
        endcase
        frame_end = (pos_reg == imafe_pkg::POS_CODE) && job_reg.byte_last;
    end

    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        pos_next  = pos_reg;
        priority if (pop_valid && pop_ready)
        begin
            job_next  = pop_job;
            busy_next = 1'b1;
            pos_next  = pop_job.hdr ? imafe_pkg::POS_PRED_LO : imafe_pkg::POS_CODE;
        end
        else if (advance && job_done)
            busy_next = 1'b0;
        else if (advance)
            pos_next = pos_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= imafe_pkg::POS_PRED_LO;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ima_adpcm_frame_encoder_core.sv -----
// IMA ADPCM frame encoder top: front end, job queue, byte emitter (imafe_pkg).
// Path: with an idle queue and emitter, a pushed job is written to the queue
// and then loaded into the emitter's job register, which raises out_valid.
// Throughput: one input item per cycle while the queue has room; one byte per
// cycle out while out_ready is high. N samples make 4 + ceil(N/2) frame bytes.
// Reset (rst_n low, async): control state cleared, queue empty, no output.
`timescale 1ns / 1ps
`default_nettype none

module ima_adpcm_frame_encoder_core
#(
    parameter int unsigned QUEUE_DEPTH = imafe_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic signed [15:0] sample,
    input  wire logic               frame_last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    frame_end
);

    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;
    imafe_pkg::job_t push_job, pop_job;

    imafe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sample     (sample),
        .frame_last (frame_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    imafe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    imafe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire

// ----- sv/imafe_checker.sv -----
// Port-level checker for the encoder output stream, bound to the top level.
// Tracks the byte position within a frame; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module imafe_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       frame_end
);

    logic [2:0] fpos_reg, fpos_next;
    logic       out_acc;

    assign out_acc = out_valid && out_ready;

    // Byte position in the frame, saturating past the header
    always_comb
    begin
        fpos_next = fpos_reg;
        if (out_acc)
        begin
            if (frame_end)
                fpos_next = 3'd0;
            else if (fpos_reg != 3'd4)
                fpos_next = fpos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fpos_reg <= 3'd0;
        else
            fpos_reg <= fpos_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
        else $error("output item changed while stalled");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && fpos_reg == 3'd2 |-> out_byte <= 8'd88)
        else $error("header step index above 88");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && fpos_reg == 3'd3 |-> out_byte == 8'h00)
        else $error("fourth header byte not zero");

    a_end_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && frame_end |-> fpos_reg == 3'd4)
        else $error("frame ended inside its header");

endmodule

bind ima_adpcm_frame_encoder_core imafe_checker u_imafe_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end)
);

`default_nettype wire
